// ===== hw/rtl/psdu_pkg.sv =====
// Shared types and constants for the particle seek/damp update pipeline.
// No dependencies.
`timescale 1ns / 1ps
package psdu_pkg;
  localparam int unsigned DW      = 32;
  localparam int unsigned FRAC_BITS = 16; // fraction bits of all fixed-point values
  localparam int unsigned DIFF_W  = 34;   // goal - saturated pos
  localparam int unsigned MAG_W   = 33;   // |diff|
  localparam int unsigned SQ_W    = 67;   // sum of three squares
  localparam int unsigned ROOT_W  = 34;   // floor sqrt of SQ_W bits
  localparam int unsigned GAIN_W  = 17;
  localparam int unsigned THR_W   = 23;
  localparam int unsigned NUM_W   = 50;   // gain * |diff|
  localparam int unsigned ADDR_W  = 4;

  typedef enum logic [1:0] {
    REG_SEEK_GAIN    = 2'd0,
    REG_MOVE_DAMPING = 2'd1,
    REG_STOP_DAMPING = 2'd2,
    REG_NEAR_THRESH  = 2'd3
  } reg_idx_t;

  function automatic logic signed [DW-1:0] sat32(input logic signed [63:0] x);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    begin
      hi = 64'sd2147483647;
      lo = -64'sd2147483648;
      if (x > hi) sat32 = 32'sh7fffffff;
      else if (x < lo) sat32 = 32'sh80000000;
      else sat32 = x[DW-1:0];
    end
  endfunction
endpackage

// ===== hw/rtl/particle_seek_damped_update.sv =====
// Top level of the particle seek/damp update: config registers and pipeline.
// Depends on psdu_pkg.
`timescale 1ns / 1ps
// Usage:
//  One particle record (pos, vel, goal; signed fixed point) enters per beat
//  on in_*; one result beat (new pos, new vel, is_near) leaves on out_*.
//  Handshake: a beat moves when valid is high and stall is low.
//  Throughput: one item per cycle unless out_stall holds the last beat.
//  Every stage is a register with a valid bit; the entire pipeline
//  advances whenever the last stage is empty or being taken, so a stall
//  on out_stall freezes all stages and is seen as in_stall in the same
//  cycle. Nothing is lost or repeated. Stages, in order: pos add,
//  squares, sum, root (ROOT_W stages, one bit per stage), divide (NUM_W
//  stages, one quotient bit per stage), add/scale product, shift/sat; the
//  depth is set by the restoring root and divide chains.
//  Reset: rst_n (synchronous, low) empties the pipeline and loads the
//  default gains and threshold. The user must write registers over the
//  APB-style port only while the pipeline is empty; the block does not enforce it.
module particle_seek_damped_update
  import psdu_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic psel, input logic penable, input logic pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready,
  input  logic in_valid, output logic in_stall,
  input  logic signed [31:0] in_pos_x, input logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic signed [31:0] in_vel_x, input logic signed [31:0] in_vel_y,
  input  logic signed [31:0] in_vel_z,
  input  logic signed [31:0] in_goal_x, input logic signed [31:0] in_goal_y,
  input  logic signed [31:0] in_goal_z,
  output logic out_valid, input logic out_stall,
  output logic signed [31:0] out_new_pos_x, output logic signed [31:0] out_new_pos_y,
  output logic signed [31:0] out_new_pos_z,
  output logic signed [31:0] out_new_vel_x, output logic signed [31:0] out_new_vel_y,
  output logic signed [31:0] out_new_vel_z,
  output logic out_is_near
);
  localparam int RS   = ROOT_W;       // root stages
  localparam int DS   = NUM_W;        // divide stages
  localparam int NS   = 3 + RS + DS + 2;

  logic [GAIN_W-1:0] seek_gain_r, move_damp_r, stop_damp_r;
  logic [THR_W-1:0]  thresh_r;
  reg_idx_t widx;
  assign pready = 1'b1;
  assign widx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seek_gain_r <= 17'd19661; move_damp_r <= 17'd52429;
      stop_damp_r <= 17'd6554;  thresh_r <= 23'd6554;
    end else if (psel && penable && pwrite) begin
      unique case (widx)
        REG_SEEK_GAIN:    seek_gain_r <= pwdata[GAIN_W-1:0];
        REG_MOVE_DAMPING: move_damp_r <= pwdata[GAIN_W-1:0];
        REG_STOP_DAMPING: stop_damp_r <= pwdata[GAIN_W-1:0];
        REG_NEAR_THRESH:  thresh_r    <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      REG_SEEK_GAIN:    prdata = {15'd0, seek_gain_r};
      REG_MOVE_DAMPING: prdata = {15'd0, move_damp_r};
      REG_STOP_DAMPING: prdata = {15'd0, stop_damp_r};
      REG_NEAR_THRESH:  prdata = {9'd0, thresh_r};
      default:          prdata = 32'd0;
    endcase
  end

  // global advance: whole pipe moves unless the output holds a stalled beat
  logic adv;
  logic [NS-1:0] vld_r;
  assign adv      = !(vld_r[NS-1] && out_stall);
  assign in_stall = !adv;
  assign out_valid = vld_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[NS-2:0], in_valid};
  end

  // stage 0: position update, difference
  logic signed [31:0] np_r [3];
  logic signed [31:0] v_r  [3];
  logic signed [DIFF_W-1:0] d_r [3];
  logic signed [31:0] pin [3], vin [3], gin [3];
  assign pin = '{in_pos_x, in_pos_y, in_pos_z};
  assign vin = '{in_vel_x, in_vel_y, in_vel_z};
  assign gin = '{in_goal_x, in_goal_y, in_goal_z};

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        np_r[i] <= sat32(64'(pin[i]) + 64'(vin[i]));
        d_r[i]  <= DIFF_W'(gin[i]) - DIFF_W'(sat32(64'(pin[i]) + 64'(vin[i])));
      end
      v_r <= vin;
    end
  end

  // stage 1: magnitudes squared
  logic [MAG_W-1:0] m1_r [3];
  logic [2*MAG_W-1:0] sq_r [3];
  logic signed [31:0] np1_r [3], v1_r [3];
  logic [2:0] neg1_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        logic [MAG_W-1:0] m;
        m = d_r[i][DIFF_W-1] ? MAG_W'(-d_r[i]) : MAG_W'(d_r[i]);
        m1_r[i]   <= m;
        sq_r[i]   <= m * m;
        neg1_r[i] <= d_r[i][DIFF_W-1];
      end
      np1_r <= np_r; v1_r <= v_r;
    end
  end

  // stage 2: sum
  typedef struct packed {
    logic [2:0] neg;
    logic [3*MAG_W-1:0] mag;
    logic [3*DW-1:0] np;
    logic [3*DW-1:0] v;
  } carry_t;
  carry_t c2_r;
  logic [SQ_W-1:0] sum_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      sum_r <= SQ_W'(sq_r[0]) + SQ_W'(sq_r[1]) + SQ_W'(sq_r[2]);
      c2_r.neg <= neg1_r;
      c2_r.mag <= {m1_r[2], m1_r[1], m1_r[0]};
      c2_r.np  <= {np1_r[2], np1_r[1], np1_r[0]};
      c2_r.v   <= {v1_r[2], v1_r[1], v1_r[0]};
    end
  end

  // root stages: one result bit per stage (restoring, remainder form)
  // sum is 67 bits; pad to 68 for the bit-pair walk
  // (first stage consumes the top pair including an implicit zero)
  localparam int RW = SQ_W + 2;
  localparam int XW = SQ_W + 1;
  logic [XW-1:0]    rx_r  [RS+1];
  logic [RW-1:0]    rrem_r[RS+1];
  logic [ROOT_W-1:0] rq_r [RS+1];
  carry_t           rc_r  [RS+1];
  always_comb begin
    rx_r[0] = {1'b0, sum_r}; rrem_r[0] = '0; rq_r[0] = '0; rc_r[0] = c2_r;
  end
  for (genvar s = 0; s < RS; s++) begin : g_root
    logic [RW-1:0] rem_sh;
    assign rem_sh = {rrem_r[s][RW-3:0], rx_r[s][XW-1 -: 2]};
    always_ff @(posedge clk) begin
      if (adv) begin
        rx_r[s+1] <= {rx_r[s][XW-3:0], 2'b00};
        if (rem_sh >= RW'({rq_r[s], 2'b01})) begin
          rrem_r[s+1] <= rem_sh - RW'({rq_r[s], 2'b01});
          rq_r[s+1]   <= {rq_r[s][ROOT_W-2:0], 1'b1};
        end else begin
          rrem_r[s+1] <= rem_sh;
          rq_r[s+1]   <= {rq_r[s][ROOT_W-2:0], 1'b0};
        end
        rc_r[s+1] <= rc_r[s];
      end
    end
  end

  // seek decision and numerators
  logic seek;
  logic [ROOT_W-1:0] root_dist;
  assign root_dist = rq_r[RS];
  assign seek = root_dist > ROOT_W'(thresh_r);

  // divide stages: three lanes sharing the divisor
  localparam int DRW = ROOT_W + 1;
  logic [NUM_W-1:0]  dn_r  [DS+1][3];
  logic [DRW-1:0]    drem_r[DS+1][3];
  logic [ROOT_W-1:0] dd_r  [DS+1];
  logic              ds_r  [DS+1];
  carry_t            dc_r  [DS+1];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dn_r[0][i]   = seek_gain_r * rc_r[RS].mag[i*MAG_W +: MAG_W];
      drem_r[0][i] = '0;
    end
    dd_r[0] = root_dist; ds_r[0] = seek; dc_r[0] = rc_r[RS];
  end
  for (genvar s = 0; s < DS; s++) begin : g_div
    always_ff @(posedge clk) begin
      if (adv) begin
        for (int i = 0; i < 3; i++) begin
          logic [DRW-1:0] r;
          r = {drem_r[s][i][DRW-2:0], dn_r[s][i][NUM_W-1]};
          if (ds_r[s] && r >= DRW'(dd_r[s])) begin
            drem_r[s+1][i] <= r - DRW'(dd_r[s]);
            dn_r[s+1][i]   <= {dn_r[s][i][NUM_W-2:0], 1'b1};
          end else begin
            drem_r[s+1][i] <= r;
            dn_r[s+1][i]   <= {dn_r[s][i][NUM_W-2:0], 1'b0};
          end
        end
        dd_r[s+1] <= dd_r[s]; ds_r[s+1] <= ds_r[s]; dc_r[s+1] <= dc_r[s];
      end
    end
  end

  // add and multiply stage; |v + t| stays below 2^33
  logic [50:0] prod_r [3];
  logic        pneg_r [3];
  logic        near_r, near2_r;
  logic signed [31:0] npa_r [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        logic signed [63:0] vv, s;
        logic [33:0] ms;
        vv = 64'(signed'(dc_r[DS].v[i*DW +: DW]));
        if (ds_r[DS])
          s = dc_r[DS].neg[i] ? vv - 64'(dn_r[DS][i]) : vv + 64'(dn_r[DS][i]);
        else s = vv;
        ms = s[63] ? 34'(-s) : 34'(s);
        prod_r[i] <= 51'(ms) * 51'(ds_r[DS] ? move_damp_r : stop_damp_r);
        pneg_r[i] <= s[63];
        npa_r[i]  <= signed'(dc_r[DS].np[i*DW +: DW]);
      end
      near_r <= !ds_r[DS];
    end
  end

  // shift and saturate stage
  logic signed [31:0] nv_r [3], npo_r [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        logic [50:0] sh;
        logic signed [63:0] t;
        sh = prod_r[i] >> FRAC_BITS;
        t = pneg_r[i] ? -64'(sh) : 64'(sh);
        nv_r[i] <= sat32(t);
      end
      npo_r <= npa_r; near2_r <= near_r;
    end
  end

  assign out_new_pos_x = npo_r[0]; assign out_new_pos_y = npo_r[1];
  assign out_new_pos_z = npo_r[2];
  assign out_new_vel_x = nv_r[0];  assign out_new_vel_y = nv_r[1];
  assign out_new_vel_z = nv_r[2];
  assign out_is_near   = near2_r;
endmodule

// ===== bench/tb.sv =====
// Self-checking bench for particle_seek_damped_update: directed table, then random records.
// Depends on psdu_pkg and the RTL top level; predicts each beat in plain SystemVerilog.
`timescale 1ns / 1ps
module tb
  import psdu_pkg::*;
();

  localparam int LATENCY = 90;   // pipeline depth is 89 stages
  localparam int FRAC    = 16;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0, in_stall;
  logic signed [31:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic signed [31:0] in_vel_x = '0, in_vel_y = '0, in_vel_z = '0;
  logic signed [31:0] in_goal_x = '0, in_goal_y = '0, in_goal_z = '0;
  logic out_valid, out_stall = 1'b0;
  logic signed [31:0] out_new_pos_x, out_new_pos_y, out_new_pos_z;
  logic signed [31:0] out_new_vel_x, out_new_vel_y, out_new_vel_z;
  logic out_is_near;

  particle_seek_damped_update DUT (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_pos_z(in_pos_z),
    .in_vel_x(in_vel_x), .in_vel_y(in_vel_y), .in_vel_z(in_vel_z),
    .in_goal_x(in_goal_x), .in_goal_y(in_goal_y), .in_goal_z(in_goal_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_new_pos_x(out_new_pos_x), .out_new_pos_y(out_new_pos_y),
    .out_new_pos_z(out_new_pos_z),
    .out_new_vel_x(out_new_vel_x), .out_new_vel_y(out_new_vel_y),
    .out_new_vel_z(out_new_vel_z),
    .out_is_near(out_is_near)
  );

  always #10 clk = ~clk;

  typedef struct packed {
    logic signed [2:0][31:0] pos;
    logic signed [2:0][31:0] vel;
    logic signed [2:0][31:0] goal;
  } particle_t;

  typedef struct packed {
    logic signed [2:0][31:0] pos;
    logic signed [2:0][31:0] vel;
    logic near;
  } update_t;

  // directed row: record plus an optional hand-typed result
  typedef struct {
    particle_t rec;
    bit        typed;
    update_t   res;
  } row_t;

  // bench copy of the gain registers
  logic [16:0] gain_q, move_q, stop_q;
  logic [22:0] thresh_q;

  update_t pending_updates[$];
  int mismatches = 0;
  int results_seen = 0;
  int near_seen = 0;
  bit in_hold_idle = 1'b0;   // sender-side no-idle stretch
  bit out_no_stall = 1'b0;   // receiver-side no-stall stretch

  function automatic logic signed [63:0] clamp32(logic signed [63:0] x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic logic [63:0] abs64(logic signed [63:0] x);
    return x < 0 ? -x : x;
  endfunction

  // s * k >> FRAC, truncated toward zero
  function automatic logic signed [63:0] fx_scale(logic signed [63:0] s, logic [16:0] k);
    logic [127:0] p;
    p = ({64'd0, abs64(s)} * {111'd0, k}) >> FRAC;
    return s < 0 ? -$signed(p[63:0]) : $signed(p[63:0]);
  endfunction

  function automatic update_t predict_update(particle_t r);
    update_t u;
    logic signed [63:0] np[3], dv[3], t, w;
    logic [127:0] sq, m, c;
    logic [63:0] root, q;
    bit seek;
    sq = '0;
    for (int i = 0; i < 3; i++) begin
      np[i] = clamp32(64'($signed(r.pos[i])) + 64'($signed(r.vel[i])));
      dv[i] = 64'($signed(r.goal[i])) - np[i];
      m = {64'd0, abs64(dv[i])};
      sq += m * m;
    end
    root = '0;
    for (int b = 33; b >= 0; b--) begin
      c = {64'd0, root | (64'd1 << b)};
      if (c * c <= sq) root = c[63:0];
    end
    seek = root > {41'd0, thresh_q};
    for (int i = 0; i < 3; i++) begin
      u.pos[i] = np[i][31:0];
      if (seek) begin
        q = ({47'd0, gain_q} * abs64(dv[i])) / root;
        t = dv[i] < 0 ? -$signed(q) : $signed(q);
        w = clamp32(fx_scale(64'($signed(r.vel[i])) + t, move_q));
      end else begin
        w = clamp32(fx_scale(64'($signed(r.vel[i])), stop_q));
      end
      u.vel[i] = w[31:0];
    end
    u.near = !seek;
    return u;
  endfunction

  function automatic particle_t rand_particle();
    particle_t r;
    int mode;
    mode = $urandom_range(0, 9);
    for (int i = 0; i < 3; i++) begin
      r.pos[i] = $urandom();
      r.vel[i] = $urandom();
      r.goal[i] = $urandom();
      if (mode < 4) begin
        // modest values: normal seeking motion
        r.pos[i] = $signed(r.pos[i]) >>> 8;
        r.vel[i] = $signed(r.vel[i]) >>> 14;
        r.goal[i] = $signed(r.goal[i]) >>> 8;
      end else if (mode < 7) begin
        // goal close to the moved position: near / threshold region
        r.pos[i] = $signed(r.pos[i]) >>> 4;
        r.vel[i] = $signed(r.vel[i]) >>> 12;
        r.goal[i] = $signed(r.pos[i]) + $signed(r.vel[i])
                    + ($signed(32'($urandom())) >>> $urandom_range(8, 24));
      end
    end
    return r;
  endfunction

  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= ADDR_W'(idx) << 2; pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_SEEK_GAIN:    gain_q = value[16:0];
      REG_MOVE_DAMPING: move_q = value[16:0];
      REG_STOP_DAMPING: stop_q = value[16:0];
      REG_NEAR_THRESH:  thresh_q = value[22:0];
    endcase
  endtask

  task automatic set_gains(logic [31:0] g, logic [31:0] mv, logic [31:0] st, logic [31:0] th);
    write_reg(REG_SEEK_GAIN, g);
    write_reg(REG_MOVE_DAMPING, mv);
    write_reg(REG_STOP_DAMPING, st);
    write_reg(REG_NEAR_THRESH, th);
  endtask

  // drain then let the pipeline settle before a register write
  task automatic wait_drained();
    while (pending_updates.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  // one beat; idles on the sender side unless a no-idle stretch is on
  task automatic send_particle(particle_t r, update_t expd);
    @(negedge clk);
    while (!in_hold_idle && $urandom_range(0, 99) < 27) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    {in_pos_x, in_pos_y, in_pos_z} <= {r.pos[0], r.pos[1], r.pos[2]};
    {in_vel_x, in_vel_y, in_vel_z} <= {r.vel[0], r.vel[1], r.vel[2]};
    {in_goal_x, in_goal_y, in_goal_z} <= {r.goal[0], r.goal[1], r.goal[2]};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    pending_updates = {pending_updates, expd};
  endtask

  // receiver stall pattern, changed at the falling edge
  always @(negedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= !out_no_stall && ($urandom_range(0, 99) < 27);
  end

  // result checker, sampled at the rising edge
  always @(posedge clk) begin
    update_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got.pos = {out_new_pos_z, out_new_pos_y, out_new_pos_x};
      got.vel = {out_new_vel_z, out_new_vel_y, out_new_vel_x};
      got.near = out_is_near;
      results_seen++;
      if (out_is_near) near_seen++;
      if (pending_updates.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %0d", results_seen);
      end else begin
        want = pending_updates.pop_front();
        for (int i = 0; i < 3; i++) begin
          if (got.pos[i] !== want.pos[i] || got.vel[i] !== want.vel[i]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("beat %0d axis %0d: pos exp %0d got %0d, vel exp %0d got %0d",
                       results_seen, i, want.pos[i], got.pos[i], want.vel[i], got.vel[i]);
          end
        end
        if (got.near !== want.near) begin
          mismatches++;
          if (mismatches <= 10)
            $display("beat %0d: is_near exp %0b got %0b", results_seen, want.near, got.near);
        end
      end
    end
  end

  initial begin
    #50ms;
    $display("timeout after %0d results", results_seen);
    $display("[particle_seek_damped_update] ERROR");
    $finish;
  end

  initial begin
    row_t rows[$];
    row_t rw;
    update_t pred;
    particle_t r;
    localparam logic signed [31:0] MAXV = 32'sh7fffffff;
    localparam logic signed [31:0] MINV = 32'sh80000000;

    // reset defaults mirrored in the bench copy
    gain_q = 17'd19661; move_q = 17'd52429; stop_q = 17'd6554; thresh_q = 23'd6554;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table; typed results only where obvious
    // all zero: distance 0, near, everything zero
    rw.rec = '0; rw.typed = 1; rw.res = '0; rw.res.near = 1'b1; rows = {rows, rw};
    // position saturates high, goal on it: near, velocity scaled by 0.1
    rw.rec = '0; rw.rec.pos = {3{MAXV}}; rw.rec.vel = {3{32'sd65536}};
    rw.rec.goal = {3{MAXV}}; rw.typed = 1;
    rw.res.pos = {3{MAXV}}; rw.res.vel = {3{32'sd6554}}; rw.res.near = 1'b1;
    rows = {rows, rw};
    // position saturates low
    rw.rec.pos = {3{MINV}}; rw.rec.vel = {3{-32'sd65536}}; rw.rec.goal = {3{MINV}};
    rw.res.pos = {3{MINV}}; rw.res.vel = {3{-32'sd6554}}; rows = {rows, rw};
    // goal at the far corner: widest difference and square sum
    rw.typed = 0;
    rw.rec.pos = {3{MINV}}; rw.rec.vel = '0; rw.rec.goal = {3{MAXV}}; rows = {rows, rw};
    rw.rec.pos = {3{MAXV}}; rw.rec.vel = {3{MAXV}}; rw.rec.goal = {3{MINV}}; rows = {rows, rw};
    rw.rec.pos = '0; rw.rec.vel = {3{MINV}}; rw.rec.goal = {3{MAXV}}; rows = {rows, rw};
    rw.rec.pos = '0; rw.rec.vel = {MAXV, MINV, MAXV}; rw.rec.goal = '0; rows = {rows, rw};
    // distance right at and just past the default threshold, one axis
    rw.rec = '0; rw.rec.goal[0] = 32'sd6554; rows = {rows, rw};
    rw.rec = '0; rw.rec.goal[1] = 32'sd6555; rows = {rows, rw};
    rw.rec = '0; rw.rec.goal[2] = -32'sd6555; rw.rec.vel = {3{32'sd100}}; rows = {rows, rw};
    rw.rec = '0; rw.rec.goal = {32'sd65536, -32'sd65536, 32'sd3}; rows = {rows, rw};
    rw.rec = '0; rw.rec.pos = 32'sd1 <<< 40; rw.rec.goal = {3{-32'sd1}}; rows = {rows, rw};

    for (int i = 0; i < rows.size(); i++) begin
      pred = predict_update(rows[i].rec);
      send_particle(rows[i].rec, rows[i].typed ? rows[i].res : pred);
    end
    @(negedge clk); in_valid <= 1'b0;
    wait_drained();

    // unit gains with a 100.0 threshold, then all registers zero with a unit distance
    set_gains(32'd65536, 32'd65536, 32'd65536, 32'd6553600);
    rw.rec = '0; rw.rec.goal = {3{MAXV}}; rw.rec.vel = {3{MAXV}};
    send_particle(rw.rec, predict_update(rw.rec));
    rw.rec = '0; rw.rec.goal[0] = 32'sd6553601;
    send_particle(rw.rec, predict_update(rw.rec));
    @(negedge clk); in_valid <= 1'b0;
    wait_drained();
    set_gains(32'd0, 32'd0, 32'd0, 32'd0);
    rw.rec = '0; rw.rec.goal[2] = 32'sd1;
    send_particle(rw.rec, predict_update(rw.rec));
    rw.rec = '0;
    send_particle(rw.rec, predict_update(rw.rec));
    // out-of-range values are masked to the register width
    @(negedge clk); in_valid <= 1'b0;
    wait_drained();
    set_gains(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    r = rand_particle();
    send_particle(r, predict_update(r));
    r = rand_particle();
    send_particle(r, predict_update(r));

    // random phases, each under a different register setting
    for (int ph = 0; ph < 6; ph++) begin
      @(negedge clk); in_valid <= 1'b0;
      wait_drained();
      case (ph)
        0: set_gains(32'd19661, 32'd52429, 32'd6554, 32'd6554);
        1: set_gains(32'd65536, 32'd65536, 32'd0, 32'd1);
        2: set_gains(32'd0, 32'd1, 32'd65536, 32'd6553600);
        default: set_gains($urandom_range(0, 65536), $urandom_range(0, 65536),
                           $urandom_range(0, 65536), $urandom_range(1, 6553600));
      endcase
      for (int n = 0; n < 256; n++) begin
        // a no-idle, no-stall stretch in the middle of the second phase
        in_hold_idle = (ph == 1 && n >= 60 && n < 200);
        out_no_stall = in_hold_idle;
        // sender holds off until the pipeline is empty
        if (ph == 2 && n == 128) begin
          @(negedge clk); in_valid <= 1'b0;
          while (pending_updates.size() != 0) @(posedge clk);
        end
        r = rand_particle();
        send_particle(r, predict_update(r));
      end
    end
    @(negedge clk); in_valid <= 1'b0;
    out_no_stall = 1'b0;
    while (pending_updates.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);

    $display("checked %0d result beats (%0d near) over 10 register settings",
             results_seen, near_seen);
    if (mismatches == 0 && pending_updates.size() == 0) begin
      $display("[particle_seek_damped_update] OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("[particle_seek_damped_update] ERROR");
    end
    $finish;
  end
endmodule
